// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ped_pkg.sv
package ped_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxOut  = 3;
  localparam int unsigned CntW    = 2;

  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_2       = 8'h32;
  localparam logic [ByteW-1:0] CH_3       = 8'h33;
  localparam logic [ByteW-1:0] CH_4       = 8'h34;
  localparam logic [ByteW-1:0] CH_5       = 8'h35;
  localparam logic [ByteW-1:0] CH_6       = 8'h36;
  localparam logic [ByteW-1:0] CH_7       = 8'h37;
  localparam logic [ByteW-1:0] CH_0       = 8'h30;
  localparam logic [ByteW-1:0] CH_9       = 8'h39;
  localparam logic [ByteW-1:0] CH_UA      = 8'h41;
  localparam logic [ByteW-1:0] CH_UF      = 8'h46;
  localparam logic [ByteW-1:0] CH_LA      = 8'h61;
  localparam logic [ByteW-1:0] CH_LF      = 8'h66;

  typedef enum logic [1:0] {
    STG_IDLE    = 2'd0,
    STG_PERCENT = 2'd1,
    STG_DIGIT   = 2'd2
  } ped_stage_t;

  typedef struct packed {
    logic                        ok;
    logic [3:0]                  value;
  } ped_nibble_t;

  typedef struct packed {
    logic                        ok;
    logic [ByteW-1:0]            value;
  } ped_match_t;

  // Decoded results of one input transaction, entry 0 goes out first.
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic                        last;
  } ped_group_t;

  function automatic ped_nibble_t hex_nibble(input logic [ByteW-1:0] c);
    ped_nibble_t r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CH_LA + 8'd10);
    end
    return r;
  endfunction

  function automatic ped_match_t escape_match(input logic [ByteW-1:0] d1,
                                              input logic [ByteW-1:0] c);
    ped_nibble_t n;
    ped_match_t  r;
    logic        hit;
    n   = hex_nibble(c);
    hit = 1'b0;
    unique case (d1)
      CH_2:    hit = (n.value >= 4'd1);
      CH_3:    hit = (n.value >= 4'd10);
      CH_4:    hit = (n.value == 4'd0);
      CH_5:    hit = (n.value >= 4'd11);
      CH_6:    hit = (n.value == 4'd0);
      CH_7:    hit = (n.value >= 4'd11) && (n.value <= 4'd14);
      default: hit = 1'b0;
    endcase
    r.ok    = n.ok && hit;
    r.value = {d1[3:0], n.value};
    return r;
  endfunction

endpackage

// File: rtl/percent_escape_decoder.sv
// Streaming URL percent-escape decoder for the punctuation escapes
// %21-%2F, %3A-%3F, %40, %5B-%5F, %60 and %7B-%7E (hex letters in either case).
// Input: s_axis, one encoded character per transaction, tlast on the final one.
// Output: m_axis, one decoded character per transaction, tlast on the last
// character produced for the input string.
// Each input transaction yields zero to three output transactions: none while
// an escape is still pending, one for a plain or decoded byte, up to three when
// an escape fails or is flushed at tlast ('%', held digit, current byte).
// Each accepted transaction goes through the input register, then the result
// register, before its first output appears.
// Throughput: one input per cycle while each yields at most one output and the
// receiver is ready; n outputs of one input hold the result register until sent.
// Reset clears the pending escape and empties both registers; s_axis_tready is
// high in the cycle after reset.
// When the receiver stalls, the result register holds its data and the input
// register takes one more transaction before s_axis_tready drops.
module percent_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  logic                        in_valid;
  logic [ped_pkg::ByteW-1:0]   in_byte;
  logic                        in_last;
  logic                        can_load;
  logic                        consume;
  ped_pkg::ped_group_t         group;

  assign consume       = in_valid && can_load;
  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  ped_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (consume),
    .in_byte (in_byte),
    .in_last (in_last),
    .group   (group)
  );

  ped_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .group     (group),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: rtl/ped_decode.sv
module ped_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [ped_pkg::ByteW-1:0]    in_byte,
  input  logic                         in_last,
  output ped_pkg::ped_group_t          group
);

  ped_pkg::ped_stage_t            stage, stage_next, stage_mid;
  logic [ped_pkg::ByteW-1:0]      held, held_next, held_mid;
  ped_pkg::ped_match_t            match;
  logic                           is_digit;
  logic                           is_percent;

  assign match      = ped_pkg::escape_match(held, in_byte);
  assign is_digit   = (in_byte >= ped_pkg::CH_2) && (in_byte <= ped_pkg::CH_7);
  assign is_percent = (in_byte == ped_pkg::CH_PERCENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= ped_pkg::STG_IDLE;
      held  <= '0;
    end else if (advance) begin
      stage <= stage_next;
      held  <= held_next;
    end
  end

  // Next state
  always_comb begin
    stage_mid = is_percent ? ped_pkg::STG_PERCENT : ped_pkg::STG_IDLE;
    held_mid  = '0;
    unique case (stage)
      ped_pkg::STG_PERCENT: begin
        if (is_digit) begin
          stage_mid = ped_pkg::STG_DIGIT;
          held_mid  = in_byte;
        end
      end
      ped_pkg::STG_DIGIT: begin
        if (match.ok) begin
          stage_mid = ped_pkg::STG_IDLE;
        end
      end
      default: ;
    endcase
    stage_next = in_last ? ped_pkg::STG_IDLE : stage_mid;
    held_next  = in_last ? '0 : held_mid;
  end

  // Outputs
  always_comb begin
    logic [ped_pkg::CntW-1:0] n;
    logic                     fresh;
    n     = '0;
    fresh = 1'b1;
    group = '0;
    unique case (stage)
      ped_pkg::STG_PERCENT: begin
        if (is_digit) begin
          fresh = 1'b0;
        end else begin
          group.bytes[n] = ped_pkg::CH_PERCENT;
          n              = n + 2'd1;
        end
      end
      ped_pkg::STG_DIGIT: begin
        if (match.ok) begin
          fresh          = 1'b0;
          group.bytes[n] = match.value;
          n              = n + 2'd1;
        end else begin
          group.bytes[n] = ped_pkg::CH_PERCENT;
          n              = n + 2'd1;
          group.bytes[n] = held;
          n              = n + 2'd1;
        end
      end
      default: ;
    endcase
    if (fresh && !is_percent) begin
      group.bytes[n] = in_byte;
      n              = n + 2'd1;
    end
    if (in_last) begin
      if (stage_mid == ped_pkg::STG_PERCENT || stage_mid == ped_pkg::STG_DIGIT) begin
        group.bytes[n] = ped_pkg::CH_PERCENT;
        n              = n + 2'd1;
      end
      if (stage_mid == ped_pkg::STG_DIGIT) begin
        group.bytes[n] = held_mid;
        n              = n + 2'd1;
      end
    end
    group.cnt  = n;
    group.last = in_last;
  end

endmodule

// File: rtl/ped_out_buffer.sv
module ped_out_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  ped_pkg::ped_group_t          group,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ped_pkg::ByteW-1:0]    out_byte,
  output logic                         out_last
);

  logic [ped_pkg::CntW-1:0]                           cnt;
  logic [ped_pkg::MaxOut-1:0][ped_pkg::ByteW-1:0]     bytes;
  logic                                               last;
  logic                                               pop;

  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt == '0) || (cnt == 2'd1 && out_ready);
  assign out_valid = (cnt != '0);
  assign out_byte  = bytes[0];
  assign out_last  = last && (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= group.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= group.bytes;
      last  <= group.last;
    end else if (pop) begin
      bytes <= {{ped_pkg::ByteW{1'b0}}, bytes[ped_pkg::MaxOut-1:1]};
    end
  end

endmodule

// File: rtl/ped_checker.sv
`include "assert_macros.svh"

module ped_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  `ASSERT_ALWAYS(a_empty_after_rst, rst |=> (!m_axis_tvalid && s_axis_tready), "not empty after reset")
  `ASSERT_CLK(a_backpressure_only_on_stall, !s_axis_tready |-> m_axis_tvalid, "input stalled with no pending output")
  `ASSERT_CLK(a_valid_holds, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output transaction withdrawn")
  `ASSERT_CLK(a_payload_holds, (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output changed")

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (.*);
